[design/bal_pkg.sv]
// Shared types and constants for the bounded array list.
package bal_pkg;

  localparam int unsigned BAL_DEPTH = 16;
  localparam int unsigned BAL_VAL_W = 32;
  localparam int unsigned BAL_POS_W = 5;
  localparam int unsigned BAL_IDX_W = 4;
  localparam int unsigned BAL_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_SORTED = 2'd3
  } bal_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } bal_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHUP_RD,
    ST_SHUP_WR,
    ST_PLACE,
    ST_SHDN_RD,
    ST_SHDN_WR,
    ST_DEL_FIN
  } bal_state_e;

  typedef struct packed {
    bal_cmd_e                      cmd;
    logic signed [BAL_VAL_W-1:0]   value;
    logic        [BAL_POS_W-1:0]   position;
  } bal_req_t;

  typedef struct packed {
    bal_status_e                   status;
    logic        [BAL_IDX_W-1:0]   index;
    logic        [BAL_CNT_W-1:0]   entry_count;
  } bal_rsp_t;

  // Result of the shared comparator.
  typedef struct packed {
    logic eq;
    logic lt;
  } bal_cmp_t;

endpackage

[design/bal_cmp.sv]
// Shared signed comparator used by the locate and sorted-insert scans.
module bal_cmp
  import bal_pkg::*;
(
  input  logic signed [BAL_VAL_W-1:0] a_i,
  input  logic signed [BAL_VAL_W-1:0] b_i,
  output bal_cmp_t                    res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.lt = (a_i < b_i);

endmodule

[design/bounded_array_list.sv]
// Top level of the bounded array list: sequencer, entry memory and result register.
//
// Usage: present a command on in_i and raise start; it is taken at a rising edge where
// busy is low. busy stays high while the sequencer walks the entry memory. The result
// appears on out_o for exactly one cycle with done_o high; the receiver cannot stall
// it, so it must take the result in that cycle.
// The entry memory has one read and one write port with a registered read, so every
// moved or compared entry costs two cycles of the sequencer:
//   error results (full, bad position, locate on empty list): done_o
//     one cycle after the transfer, busy never rises
//   insert-at:     2*(count-pos) + 1 cycles busy
//   delete-at:     2*(count-pos-1) + 1 cycles busy
//   locate:        2*(k+1) cycles busy, k the hit position (count-1 on a miss)
//   sorted insert: 2*(p+1) + 2*(count-p) + 1 cycles busy when the entry at p is not
//     below the value, else 2*count + 1 (value goes at the end, empty list included)
// done_o rises one cycle after the last busy cycle, when busy is already low, and a
// new command may be taken in that same cycle.
// Reset clears the count and the sequencer; entry contents are not cleared, since
// only entries below the count are ever read.
module bounded_array_list
  import bal_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = BAL_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bal_req_t in_i,
  output logic     done_o,
  output bal_rsp_t out_o
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CMP_W = (CNT_W > BAL_POS_W) ? CNT_W : BAL_POS_W;

  bal_state_e state_q, state_d;
  bal_cmd_e   cmd_q, cmd_d;
  logic signed [BAL_VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;
  bal_rsp_t         rsp_q, rsp_d;

  logic signed [BAL_VAL_W-1:0] mem [LIST_DEPTH];
  logic signed [BAL_VAL_W-1:0] rdata_q;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  logic signed [BAL_VAL_W-1:0] wdata;
  logic                        mem_we;

  logic             accept;
  logic             full;
  logic             ins_bad;
  logic             del_bad;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] in_pos;
  bal_cmp_t         cmp;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_q == CNT_W'(LIST_DEPTH));
  assign ins_bad   = (CMP_W'(in_i.position) > CMP_W'(count_q));
  assign del_bad   = (CMP_W'(in_i.position) >= CMP_W'(count_q));
  assign in_pos    = CNT_W'(in_i.position);
  assign ptr_inc   = ptr_q + 1'b1;
  assign ptr_dec   = ptr_q - 1'b1;
  assign count_inc = count_q + 1'b1;
  assign count_dec = count_q - 1'b1;

  bal_cmp u_cmp (
    .a_i   (rdata_q),
    .b_i   (val_q),
    .res_o (cmp)
  );

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.cmd)
            CMD_INSERT: begin
              if (!full && !ins_bad) begin
                state_d = (count_q > in_pos) ? ST_SHUP_RD : ST_PLACE;
              end
            end
            CMD_DELETE: begin
              if (!del_bad) begin
                state_d = (in_pos < count_dec) ? ST_SHDN_RD : ST_DEL_FIN;
              end
            end
            CMD_LOCATE: begin
              if (count_q != '0) state_d = ST_SCAN_RD;
            end
            CMD_SORTED: begin
              if (!full) state_d = (count_q != '0) ? ST_SCAN_RD : ST_PLACE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (cmd_q == CMD_LOCATE) begin
          if (cmp.eq || ptr_inc == count_q) state_d = ST_IDLE;
          else                             state_d = ST_SCAN_RD;
        end else begin
          if (!cmp.lt)                state_d = ST_SHUP_RD;
          else if (ptr_inc == count_q) state_d = ST_PLACE;
          else                        state_d = ST_SCAN_RD;
        end
      end
      ST_SHUP_RD: state_d = ST_SHUP_WR;
      ST_SHUP_WR: state_d = (ptr_dec > pos_q) ? ST_SHUP_RD : ST_PLACE;
      ST_PLACE:   state_d = ST_IDLE;
      ST_SHDN_RD: state_d = ST_SHDN_WR;
      ST_SHDN_WR: state_d = (ptr_inc < count_dec) ? ST_SHDN_RD : ST_DEL_FIN;
      ST_DEL_FIN: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and result logic
  always_comb begin
    cmd_d             = cmd_q;
    val_d             = val_q;
    ptr_d             = ptr_q;
    pos_d             = pos_q;
    count_d           = count_q;
    done_d            = 1'b0;
    rsp_d             = rsp_q;
    raddr             = ptr_q[AW-1:0];
    waddr             = ptr_q[AW-1:0];
    wdata             = rdata_q;
    mem_we            = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d             = in_i.cmd;
          val_d             = in_i.value;
          rsp_d.index       = '0;
          rsp_d.entry_count = BAL_CNT_W'(count_q);
          unique case (in_i.cmd)
            CMD_INSERT: begin
              if (full) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_FULL;
              end else if (ins_bad) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_BADPOS;
              end else begin
                pos_d = in_pos;
                ptr_d = count_q;
              end
            end
            CMD_DELETE: begin
              if (del_bad) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_BADPOS;
              end else begin
                pos_d = in_pos;
                ptr_d = in_pos;
              end
            end
            CMD_LOCATE: begin
              ptr_d = '0;
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_NOTFOUND;
              end
            end
            CMD_SORTED: begin
              ptr_d = '0;
              pos_d = '0;
              if (full) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_FULL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: raddr = ptr_q[AW-1:0];
      ST_SCAN_CMP: begin
        if (cmd_q == CMD_LOCATE) begin
          if (cmp.eq) begin
            done_d            = 1'b1;
            rsp_d.status      = STAT_OK;
            rsp_d.index       = BAL_IDX_W'(ptr_q);
            rsp_d.entry_count = BAL_CNT_W'(count_q);
          end else if (ptr_inc == count_q) begin
            done_d            = 1'b1;
            rsp_d.status      = STAT_NOTFOUND;
            rsp_d.index       = '0;
            rsp_d.entry_count = BAL_CNT_W'(count_q);
          end else begin
            ptr_d = ptr_inc;
          end
        end else begin
          // First entry not below the value marks the placement slot.
          if (!cmp.lt) begin
            pos_d = ptr_q;
            ptr_d = count_q;
          end else if (ptr_inc == count_q) begin
            pos_d = count_q;
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end
      ST_SHUP_RD: raddr = ptr_dec[AW-1:0];
      ST_SHUP_WR: begin
        mem_we = 1'b1;
        waddr  = ptr_q[AW-1:0];
        wdata  = rdata_q;
        ptr_d  = ptr_dec;
      end
      ST_PLACE: begin
        mem_we            = 1'b1;
        waddr             = pos_q[AW-1:0];
        wdata             = val_q;
        count_d           = count_inc;
        done_d            = 1'b1;
        rsp_d.status      = STAT_OK;
        rsp_d.index       = BAL_IDX_W'(pos_q);
        rsp_d.entry_count = BAL_CNT_W'(count_inc);
      end
      ST_SHDN_RD: raddr = ptr_inc[AW-1:0];
      ST_SHDN_WR: begin
        mem_we = 1'b1;
        waddr  = ptr_q[AW-1:0];
        wdata  = rdata_q;
        ptr_d  = ptr_inc;
      end
      ST_DEL_FIN: begin
        count_d           = count_dec;
        done_d            = 1'b1;
        rsp_d.status      = STAT_OK;
        rsp_d.index       = BAL_IDX_W'(pos_q);
        rsp_d.entry_count = BAL_CNT_W'(count_dec);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign done_o = done_q;
  assign out_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count exceeds list depth");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> busy)
    else $error("memory write outside a command");

  a_accept_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted command neither started nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still busy");

endmodule
